// ===== hdl/png_idat_stored_zlib_framer_unit_defines.svh =====
// Assertion macros shared by the framer.
`ifndef PNG_IDAT_STORED_ZLIB_FRAMER_UNIT_DEFINES_SVH
`define PNG_IDAT_STORED_ZLIB_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PNGIDAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PNGIDAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pngidat_pkg.sv =====
package pngidat_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_INIT   = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG   = 8'h01;
    localparam logic [7:0]  TYPE_I     = 8'h49;
    localparam logic [7:0]  TYPE_D     = 8'h44;
    localparam logic [7:0]  TYPE_A     = 8'h41;
    localparam logic [7:0]  TYPE_T     = 8'h54;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_TYPE,
        PH_ZHDR,
        PH_BHDR,
        PH_DATA,
        PH_ADLER,
        PH_CRC
    } phase_t;

    // One classified input byte, as handed from front to back.
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        blk;
        logic        blk_final;
        logic        last;
        logic [15:0] blk_count;
        logic [31:0] adler;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/pngidat_len_div.sv =====
module pngidat_len_div
    import pngidat_pkg::*;
#(
    parameter int BLOCK_MAX   = 65535,
    parameter int LENGTH_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   we,
    input  logic [LENGTH_BITS-1:0] wdata,
    output logic                   busy,
    output logic [31:0]            chunk_len
);

    localparam int NW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;
    // reciprocal of BLOCK_MAX, exact for every numerator below 2**NW
    localparam int SH = NW + $clog2(BLOCK_MAX);
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(BLOCK_MAX) - 64'd1) / 64'(BLOCK_MAX);
    localparam int MW = NW + 1;
    localparam int PW = NW + MW;
    localparam logic [MW-1:0] RECIP_W = MW'(RECIP);

    logic [LENGTH_BITS-1:0] eff;
    logic [LENGTH_BITS-1:0] eff_reg;
    logic [NW-1:0]          num_reg;
    logic [PW-1:0]          prod_reg;
    logic [PW-1:0]          prod_next;
    logic [PW-SH-1:0]       blocks;
    logic                   step_reg;
    logic                   busy_reg;
    logic [31:0]            len_reg;
    logic [31:0]            len_next;

    assign eff = (wdata == '0) ? LENGTH_BITS'(1) : wdata;

    // block count = ceil(eff / BLOCK_MAX) by multiply and shift
    assign prod_next = PW'(num_reg) * PW'(RECIP_W);
    assign blocks    = prod_reg[PW-1:SH];
    assign len_next  = 32'(eff_reg) + (32'(blocks) << 2) + 32'(blocks) + 32'd6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
            len_reg  <= 32'd12;
        end
        else if (we)
        begin
            busy_reg <= 1'b1;
            step_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                step_reg <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
                len_reg  <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            eff_reg <= eff;
            num_reg <= NW'(eff) + NW'(BLOCK_MAX - 1);
        end
        else if (busy_reg && !step_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign busy      = busy_reg;
    assign chunk_len = len_reg;

endmodule

// ===== hdl/pngidat_front.sv =====
module pngidat_front
    import pngidat_pkg::*;
#(
    parameter int BLOCK_MAX   = 65535,
    parameter int LENGTH_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic [LENGTH_BITS-1:0] total_length,
    input  logic                   len_busy,
    input  q_status_t              q_stat,
    output logic                   push,
    output entry_t                 push_entry
);

    localparam int LB = LENGTH_BITS;

    logic [LB-1:0] bytes_done_reg;
    logic [15:0]   block_left_reg;
    logic [15:0]   adler_low_reg;
    logic [15:0]   adler_high_reg;

    logic [LB-1:0] eff_total;
    logic [LB-1:0] remaining;
    logic          blk;
    logic          blk_final;
    logic [15:0]   blk_count;
    logic [15:0]   block_left_next;
    logic [LB:0]   done_inc;
    logic          last;
    logic [16:0]   low_sum;
    logic [15:0]   low_new;
    logic [16:0]   high_sum;
    logic [15:0]   high_new;

    assign eff_total = (total_length == '0) ? LB'(1) : total_length;
    // a shortened length leaves nothing due: the block is sized one
    assign remaining = (eff_total > bytes_done_reg) ? eff_total - bytes_done_reg : LB'(1);
    assign blk       = block_left_reg == '0;
    assign blk_final = 32'(remaining) <= 32'(BLOCK_MAX);
    assign blk_count = blk_final ? 16'(remaining) : 16'(BLOCK_MAX);
    assign block_left_next = (blk ? blk_count : block_left_reg) - 16'd1;

    // wrap of the byte count also closes the chunk
    assign done_inc = {1'b0, bytes_done_reg} + (LB+1)'(1);
    assign last     = done_inc >= {1'b0, eff_total};

    assign low_sum  = {1'b0, adler_low_reg} + {9'b0, data_byte};
    assign low_new  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
    assign high_sum = {1'b0, adler_high_reg} + {1'b0, low_new};
    assign high_new = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];

    assign in_ready = !len_busy && !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_entry.data      = data_byte;
        push_entry.first     = bytes_done_reg == '0;
        push_entry.blk       = blk;
        push_entry.blk_final = blk_final;
        push_entry.last      = last;
        push_entry.blk_count = blk_count;
        push_entry.adler     = {high_new, low_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_done_reg <= '0;
            block_left_reg <= '0;
            adler_low_reg  <= 16'd1;
            adler_high_reg <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                bytes_done_reg <= '0;
                block_left_reg <= '0;
                adler_low_reg  <= 16'd1;
                adler_high_reg <= '0;
            end
            else
            begin
                bytes_done_reg <= done_inc[LB-1:0];
                block_left_reg <= block_left_next;
                adler_low_reg  <= low_new;
                adler_high_reg <= high_new;
            end
        end
    end

endmodule

// ===== hdl/pngidat_queue.sv =====
module pngidat_queue
    import pngidat_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == NW'(DEPTH);
    assign q_stat.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

// ===== hdl/pngidat_back.sv =====
module pngidat_back
    import pngidat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  q_status_t   q_stat,
    input  logic [31:0] chunk_len,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_end,
    output logic        chunk_end
);

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      cur_phase;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [2:0]  cur_idx;
    logic        emit;
    logic [7:0]  byte_sel;
    logic        crc_en;
    logic        done;
    logic        crc_last;
    logic [31:0] crc_reg;
    logic [31:0] crc_out;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        run_end_reg;
    logic        chunk_end_reg;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'b0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // a new entry starts where its flags say
    always_comb
    begin
        if (phase_reg == PH_IDLE)
        begin
            cur_phase = head.first ? PH_LEN : (head.blk ? PH_BHDR : PH_DATA);
            cur_idx   = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_idx   = idx_reg;
        end
    end

    assign emit    = !q_stat.empty && (!out_valid_reg || out_ready);
    assign crc_out = ~crc_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            phase_next = cur_phase;
            idx_next   = cur_idx + 3'd1;
            case (cur_phase)
                PH_LEN:
                    if (cur_idx == 3'd3)
                    begin
                        phase_next = PH_TYPE;
                        idx_next   = '0;
                    end
                PH_TYPE:
                    if (cur_idx == 3'd3)
                    begin
                        phase_next = PH_ZHDR;
                        idx_next   = '0;
                    end
                PH_ZHDR:
                    if (cur_idx == 3'd1)
                    begin
                        phase_next = head.blk ? PH_BHDR : PH_DATA;
                        idx_next   = '0;
                    end
                PH_BHDR:
                    if (cur_idx == 3'd4)
                    begin
                        phase_next = PH_DATA;
                        idx_next   = '0;
                    end
                PH_DATA:
                begin
                    phase_next = head.last ? PH_ADLER : PH_IDLE;
                    idx_next   = '0;
                end
                PH_ADLER:
                    if (cur_idx == 3'd3)
                    begin
                        phase_next = PH_CRC;
                        idx_next   = '0;
                    end
                PH_CRC:
                    if (cur_idx == 3'd3)
                    begin
                        phase_next = PH_IDLE;
                        idx_next   = '0;
                    end
                default:
                begin
                    phase_next = PH_IDLE;
                    idx_next   = '0;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        byte_sel = head.data;
        crc_en   = 1'b1;
        done     = 1'b0;
        crc_last = 1'b0;
        case (cur_phase)
            PH_LEN:
            begin
                byte_sel = be_byte(chunk_len, cur_idx[1:0]);
                crc_en   = 1'b0;
            end
            PH_TYPE:
                case (cur_idx[1:0])
                    2'd0:    byte_sel = TYPE_I;
                    2'd1:    byte_sel = TYPE_D;
                    2'd2:    byte_sel = TYPE_A;
                    default: byte_sel = TYPE_T;
                endcase
            PH_ZHDR:
                byte_sel = (cur_idx == 3'd0) ? ZLIB_CMF : ZLIB_FLG;
            PH_BHDR:
                case (cur_idx)
                    3'd0:    byte_sel = {7'b0, head.blk_final};
                    3'd1:    byte_sel = head.blk_count[7:0];
                    3'd2:    byte_sel = head.blk_count[15:8];
                    3'd3:    byte_sel = ~head.blk_count[7:0];
                    default: byte_sel = ~head.blk_count[15:8];
                endcase
            PH_DATA:
            begin
                byte_sel = head.data;
                done     = !head.last;
            end
            PH_ADLER:
                byte_sel = be_byte(head.adler, cur_idx[1:0]);
            PH_CRC:
            begin
                byte_sel = be_byte(crc_out, cur_idx[1:0]);
                crc_en   = 1'b0;
                done     = cur_idx == 3'd3;
                crc_last = cur_idx == 3'd3;
            end
            default:
            begin
                byte_sel = head.data;
                crc_en   = 1'b0;
            end
        endcase
    end

    assign pop = emit && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (crc_last)
                begin
                    crc_reg <= CRC_INIT;
                end
                else if (crc_en)
                begin
                    crc_reg <= crc_byte(crc_reg, byte_sel);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= byte_sel;
            run_end_reg   <= done;
            chunk_end_reg <= crc_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;
    assign chunk_end = chunk_end_reg;

endmodule

// ===== hdl/png_idat_stored_zlib_framer_unit.sv =====
// Channel   Handshake                   Payload
// --------  --------------------------  ------------------------------
// input     in_valid / in_ready         data_byte
// output    out_valid / out_ready       out_byte, run_end, chunk_end
// config    total_length_we             total_length
//
// The output port moves one chunk byte per cycle while out_ready is high and the queue is
// not empty; an input transaction causes 1 byte, plus 10 on a chunk's first byte, 5 on a
// block start, 8 on the last. A short queue between classifier and emitter lets input run
// ahead of a stalled output. After a length write in_ready is held low while the chunk
// length (block count) is worked out by a reciprocal multiply.
// Reset (rst_n, async) restores length 1 and an empty chunk; no startup delay.
`include "png_idat_stored_zlib_framer_unit_defines.svh"

module png_idat_stored_zlib_framer_unit
    import pngidat_pkg::*;
#(
    parameter int BLOCK_MAX   = 65535,
    parameter int LENGTH_BITS = 24,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   run_end,
    output logic                   chunk_end,
    input  logic                   total_length_we,
    input  logic [LENGTH_BITS-1:0] total_length
);

    logic [LENGTH_BITS-1:0] total_length_reg;
    logic                   len_busy;
    logic [31:0]            chunk_len;
    q_status_t              q_stat;
    logic                   push;
    entry_t                 push_entry;
    logic                   pop;
    entry_t                 head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= LENGTH_BITS'(1);
        end
        else if (total_length_we)
        begin
            total_length_reg <= total_length;
        end
    end

    pngidat_len_div #(
        .BLOCK_MAX   (BLOCK_MAX),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_len_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .we        (total_length_we),
        .wdata     (total_length),
        .busy      (len_busy),
        .chunk_len (chunk_len)
    );

    pngidat_front #(
        .BLOCK_MAX   (BLOCK_MAX),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .total_length (total_length_reg),
        .len_busy     (len_busy),
        .q_stat       (q_stat),
        .push         (push),
        .push_entry   (push_entry)
    );

    pngidat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    pngidat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .chunk_len (chunk_len),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_end   (run_end),
        .chunk_end (chunk_end)
    );

    `PNGIDAT_ASSERT_SAME(a_chunk_end_closes_run, clk, rst_n,
        out_valid && chunk_end, run_end, "chunk end without run end")
    `PNGIDAT_ASSERT_NEXT(a_len_write_stalls_input, clk, rst_n,
        total_length_we, !in_ready, "input taken during length update")
    `PNGIDAT_ASSERT_SAME(a_queue_status_sane, clk, rst_n,
        q_stat.full, !q_stat.empty, "queue both full and empty")

endmodule

// ===== verif/tb_png_idat_stored_zlib_framer_unit.sv =====
`timescale 1ns / 1ps

import pngidat_pkg::*;

localparam int unsigned STORED_BLOCK_MAX = 65535;

typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       chunk_end;
} idat_out_t;

// Tracks the chunk being framed and holds the IDAT bytes still owed by the block.
class idat_scoreboard;
    idat_out_t   chunk_bytes[$];
    logic [23:0] length_cfg;
    logic [23:0] bytes_done;
    logic [15:0] block_left;
    logic [15:0] adler_a;
    logic [15:0] adler_b;
    logic [31:0] crc_acc;
    int          errors;

    function new();
        length_cfg = 24'd1;
        errors = 0;
        restart();
    endfunction

    function void restart();
        bytes_done = '0;
        block_left = '0;
        adler_a = 16'd1;
        adler_b = 16'd0;
        crc_acc = CRC_INIT;
    endfunction

    function void set_length(logic [23:0] v);
        length_cfg = v;
    endfunction

    function void crc_update(logic [7:0] b);
        logic [31:0] c;
        c = crc_acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        crc_acc = c;
    endfunction

    function void put(logic [7:0] b, bit in_crc, bit txn_last, bit chunk_last);
        idat_out_t e;
        e.data = b;
        e.run_end = txn_last;
        e.chunk_end = chunk_last;
        chunk_bytes.insert(chunk_bytes.size(), e);
        if (in_crc)
            crc_update(b);
    endfunction

    function void put_be32(logic [31:0] v, bit in_crc, bit closes);
        put(v[31:24], in_crc, 1'b0, 1'b0);
        put(v[23:16], in_crc, 1'b0, 1'b0);
        put(v[15:8], in_crc, 1'b0, 1'b0);
        put(v[7:0], in_crc, closes, closes);
    endfunction

    // One accepted raw byte: queue every chunk byte it releases.
    function void note_input(logic [7:0] b);
        logic [23:0] total;
        logic [31:0] n_blocks;
        logic [23:0] remaining;
        logic [15:0] count;
        logic [15:0] inv;
        logic [16:0] sum;
        logic [23:0] done_next;
        bit          closes;
        total = (length_cfg == 24'd0) ? 24'd1 : length_cfg;
        if (bytes_done == 24'd0)
        begin
            n_blocks = ({8'd0, total} + STORED_BLOCK_MAX - 1) / STORED_BLOCK_MAX;
            put_be32({8'd0, total} + 32'd5 * n_blocks + 32'd6, 1'b0, 1'b0);
            put(TYPE_I, 1'b1, 1'b0, 1'b0);
            put(TYPE_D, 1'b1, 1'b0, 1'b0);
            put(TYPE_A, 1'b1, 1'b0, 1'b0);
            put(TYPE_T, 1'b1, 1'b0, 1'b0);
            put(ZLIB_CMF, 1'b1, 1'b0, 1'b0);
            put(ZLIB_FLG, 1'b1, 1'b0, 1'b0);
        end
        if (block_left == 16'd0)
        begin
            // length shrunk to or below what is done: a one-byte final block
            remaining = (total > bytes_done) ? total - bytes_done : 24'd1;
            count = (remaining < STORED_BLOCK_MAX) ? remaining[15:0]
                                                   : 16'(STORED_BLOCK_MAX);
            inv = ~count;
            put({7'd0, {8'd0, count} == remaining}, 1'b1, 1'b0, 1'b0);
            put(count[7:0], 1'b1, 1'b0, 1'b0);
            put(count[15:8], 1'b1, 1'b0, 1'b0);
            put(inv[7:0], 1'b1, 1'b0, 1'b0);
            put(inv[15:8], 1'b1, 1'b0, 1'b0);
            block_left = count;
        end
        done_next = bytes_done + 24'd1;
        closes = (done_next == 24'd0) || (done_next >= total);
        put(b, 1'b1, !closes, 1'b0);
        sum = {1'b0, adler_a} + {9'd0, b};
        if (sum >= ADLER_MOD)
            sum = sum - ADLER_MOD;
        adler_a = sum[15:0];
        sum = {1'b0, adler_b} + {1'b0, adler_a};
        if (sum >= ADLER_MOD)
            sum = sum - ADLER_MOD;
        adler_b = sum[15:0];
        block_left = block_left - 16'd1;
        bytes_done = done_next;
        if (closes)
        begin
            put_be32({adler_b, adler_a}, 1'b1, 1'b0);
            put_be32(~crc_acc, 1'b0, 1'b1);
            restart();
        end
    endfunction

    task report(string msg);
        if (errors < 100)
            $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [7:0] got_byte, logic got_run_end, logic got_chunk_end);
        idat_out_t want;
        if (chunk_bytes.size() == 0)
        begin
            report($sformatf("output byte %02h with nothing pending", got_byte));
            return;
        end
        want = chunk_bytes.pop_front();
        if (got_byte !== want.data)
            report($sformatf("out_byte %02h, want %02h", got_byte, want.data));
        if (got_run_end !== want.run_end)
            report($sformatf("run_end %b, want %b", got_run_end, want.run_end));
        if (got_chunk_end !== want.chunk_end)
            report($sformatf("chunk_end %b, want %b", got_chunk_end, want.chunk_end));
    endtask
endclass

module tb_png_idat_stored_zlib_framer_unit;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 140;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        chunk_end;
    logic        total_length_we;
    logic [23:0] total_length;

    bit             idle_on;
    int             quiet_cycles;
    int             random_items;
    idat_scoreboard sb;

    always #4 clk = ~clk;

    png_idat_stored_zlib_framer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .run_end         (run_end),
        .chunk_end       (chunk_end),
        .total_length_we (total_length_we),
        .total_length    (total_length)
    );

    // Config, input and output transactions are all taken here in a fixed order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (total_length_we)
                sb.set_length(total_length);
            if (in_valid && in_ready)
                sb.note_input(data_byte);
            if (out_valid && out_ready)
                sb.check_result(out_byte, run_end, chunk_end);
            if ((in_valid && in_ready) || (out_valid && out_ready) || total_length_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_png_idat_stored_zlib_framer_unit failed");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.chunk_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_length(input logic [23:0] v);
        drain();
        total_length_we = 1'b1;
        total_length = v;
        @(negedge clk);
        total_length_we = 1'b0;
    endtask

    // Feed random bytes until the chunk closes, maybe moving the length on the way.
    task automatic run_chunk(input logic [23:0] len, input bit allow_change);
        bit changed;
        changed = 1'b0;
        write_length(len);
        do
        begin
            send_byte(pick_byte());
            random_items++;
            if (allow_change && !changed && sb.bytes_done != 0 && $urandom_range(0, 3) == 0)
            begin
                changed = 1'b1;
                write_length(24'($urandom_range(0, 24)));
            end
        end
        while (sb.bytes_done != 0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        total_length_we = 1'b0;
        total_length = 24'd1;
        idle_on = 1'b1;
        quiet_cycles = 0;
        random_items = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset length of one byte
        send_byte(8'h00);
        // zero length acts as one
        write_length(24'd0);
        send_byte(8'hff);
        write_length(24'd3);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'ha5);
        // largest length, then cut short mid-chunk
        write_length(24'hffffff);
        send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h5a);
        write_length(24'd2);
        send_byte(8'h81);
        // longer length mid-chunk opens a second block
        write_length(24'd5);
        send_byte(8'h01);
        send_byte(8'hfe);
        write_length(24'd8);
        repeat (6) send_byte(pick_byte());
        // block opens after the length dropped below bytes done
        write_length(24'd3);
        send_byte(8'h7f);
        send_byte(8'h80);
        write_length(24'd6);
        send_byte(8'hc3);
        write_length(24'd2);
        send_byte(8'h3c);

        while (random_items < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: run_chunk(24'd0, 1'b0);
                1: run_chunk(24'($urandom_range(13, 64)), 1'b1);
                default: run_chunk(24'($urandom_range(1, 12)), $urandom_range(0, 4) == 0);
            endcase
        end

        // closing chunk with both sides running flat out
        idle_on = 1'b0;
        run_chunk(24'd12, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("tb_png_idat_stored_zlib_framer_unit passed");
        else
            $display("tb_png_idat_stored_zlib_framer_unit failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pngidat_pkg.sv
hdl/pngidat_len_div.sv
hdl/pngidat_front.sv
hdl/pngidat_queue.sv
hdl/pngidat_back.sv
hdl/png_idat_stored_zlib_framer_unit.sv
verif/tb_png_idat_stored_zlib_framer_unit.sv
